// ----- hw/rtl/vaos_pkg.sv -----
package vaos_pkg;

  localparam int MAX_VOICES_DEFAULT = 16;
  localparam int VOICE_FIELD_W = 4;
  localparam int POLY_W = 5;
  localparam logic [POLY_W-1:0] POLY_RESET = 5'd16;

  localparam logic CMD_NOTE_ON = 1'b0;
  localparam logic CMD_VOICE_FINISHED = 1'b1;

  typedef struct packed {
    logic                     command;
    logic [VOICE_FIELD_W-1:0] voice_index;
  } note_item_t;

  typedef struct packed {
    logic [VOICE_FIELD_W-1:0] allocated_voice;
    logic                     stolen;
  } alloc_item_t;

endpackage

// ----- hw/rtl/vaos_pick.sv -----
module vaos_pick import vaos_pkg::*; #(
  parameter int MAX_VOICES = MAX_VOICES_DEFAULT,
  localparam int VW = $clog2(MAX_VOICES)
) (
  input  logic [MAX_VOICES-1:0] active,
  input  logic [POLY_W-1:0]     poly,
  output logic                  found,
  output logic [VW-1:0]         voice
);

  // A polyphony of zero behaves as one, and one above the voice count as the voice count.
  always_comb begin
    found = 1'b0;
    voice = '0;
    for (int i = MAX_VOICES - 1; i >= 0; i--) begin
      if (!active[i] && ((i == 0) || (32'(i) < 32'(poly)))) begin
        found = 1'b1;
        voice = VW'(i);
      end
    end
  end

endmodule

// ----- hw/rtl/vaos_queue.sv -----
module vaos_queue import vaos_pkg::*; #(
  parameter int MAX_VOICES = MAX_VOICES_DEFAULT,
  localparam int VW = $clog2(MAX_VOICES),
  localparam int CW = $clog2(MAX_VOICES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          drop_en,
  input  logic [VW-1:0] drop_voice,
  input  logic          add_en,
  input  logic [VW-1:0] add_voice,
  output logic [VW-1:0] head,
  output logic [CW-1:0] count
);

  logic [VW-1:0] entries [MAX_VOICES];
  logic [VW-1:0] entries_next [MAX_VOICES];
  logic [VW-1:0] shifted [MAX_VOICES];
  logic [MAX_VOICES-1:0] match;
  logic [MAX_VOICES-1:0] past;
  logic [CW-1:0] count_drop;
  logic [CW-1:0] count_next;
  logic add_ok;

  assign head = entries[0];

  // Entries at and after the removed voice move one place toward the head.
  always_comb begin
    for (int i = 0; i < MAX_VOICES; i++) begin
      match[i] = drop_en && (CW'(i) < count) && (entries[i] == drop_voice);
    end
    past[0] = match[0];
    for (int i = 1; i < MAX_VOICES; i++) begin
      past[i] = past[i-1] | match[i];
    end
    for (int i = 0; i < MAX_VOICES; i++) begin
      shifted[i] = past[i] ? entries[(i + 1) % MAX_VOICES] : entries[i];
    end
    count_drop = count - CW'(past[MAX_VOICES-1]);
    add_ok = add_en && (count_drop < CW'(MAX_VOICES));
    count_next = count_drop + CW'(add_ok);
    for (int i = 0; i < MAX_VOICES; i++) begin
      entries_next[i] = (add_ok && (count_drop == CW'(i))) ? add_voice : shifted[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_VOICES; i++) begin
      entries[i] <= entries_next[i];
    end
  end

endmodule

// ----- hw/rtl/voice_allocator_oldest_steal_core.sv -----
// A note_on transaction is taken into the input register and its result is registered once
// the output slot is free. Throughput: one transaction per cycle unless alloc_stall holds a
// note_on, set by the single compute stage between the input register and the result
// register; a voice_finished transaction gives no result.
// Reset (synchronous, active high): all voices idle, the age queue empty, polyphony 16.
module voice_allocator_oldest_steal_core import vaos_pkg::*; #(
  parameter int MAX_VOICES = MAX_VOICES_DEFAULT,
  localparam int VW = $clog2(MAX_VOICES),
  localparam int CW = $clog2(MAX_VOICES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              note_valid,
  output logic              note_stall,
  input  note_item_t        note,
  output logic              alloc_valid,
  input  logic              alloc_stall,
  output alloc_item_t       alloc,
  input  logic              wr_en,
  input  logic [POLY_W-1:0] wr_data
);

  logic              held_valid;
  note_item_t        held;
  logic [POLY_W-1:0] poly;
  logic [MAX_VOICES-1:0] active;
  logic [MAX_VOICES-1:0] active_next;

  logic          is_fin;
  logic [VW-1:0] fin_idx;
  logic          fin_ok;
  logic          slot_free;
  logic          advance;
  logic          note_on;
  logic          found;
  logic [VW-1:0] idle_voice;
  logic [VW-1:0] head;
  logic [CW-1:0] count;
  logic          steal;
  logic [VW-1:0] chosen;

  assign is_fin = held.command == CMD_VOICE_FINISHED;
  assign fin_idx = VW'(held.voice_index);
  assign fin_ok = held_valid && is_fin && (32'(held.voice_index) < 32'(MAX_VOICES)) &&
                  active[fin_idx];
  assign slot_free = !alloc_valid || !alloc_stall;
  assign advance = held_valid && (is_fin || slot_free);
  assign note_stall = held_valid && !advance;
  assign note_on = advance && !is_fin;
  assign steal = note_on && !found && (count != '0);
  assign chosen = found ? idle_voice : ((count != '0) ? head : '0);

  vaos_pick #(
    .MAX_VOICES(MAX_VOICES)
  ) u_pick (
    .active(active),
    .poly(poly),
    .found(found),
    .voice(idle_voice)
  );

  vaos_queue #(
    .MAX_VOICES(MAX_VOICES)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .drop_en(fin_ok || steal),
    .drop_voice(is_fin ? fin_idx : head),
    .add_en(note_on),
    .add_voice(chosen),
    .head(head),
    .count(count)
  );

  always_comb begin
    active_next = active;
    if (fin_ok) begin
      active_next[fin_idx] = 1'b0;
    end
    if (note_on) begin
      active_next[chosen] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      alloc_valid <= 1'b0;
      active <= '0;
      poly <= POLY_RESET;
    end else begin
      active <= active_next;
      if (wr_en) begin
        poly <= wr_data;
      end
      if (note_valid && !note_stall) begin
        held_valid <= 1'b1;
      end else if (advance) begin
        held_valid <= 1'b0;
      end
      if (note_on) begin
        alloc_valid <= 1'b1;
      end else if (!alloc_stall) begin
        alloc_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (note_valid && !note_stall) begin
      held <= note;
    end
    if (note_on) begin
      alloc.allocated_voice <= VOICE_FIELD_W'(chosen);
      alloc.stolen <= !found;
    end
  end

endmodule
